// ----- design/msmnn_pkg.sv -----
// ----------------------------------------------------------------------------
// msmnn_pkg
// Shared types, constants and arithmetic helpers for the MSM nearest
// neighbour classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package msmnn_pkg;

  localparam int MAX_LEN_DEF = 256;

  localparam logic [31:0] COST_INF  = 32'hFFFF_FFFF;
  localparam logic [6:0]  SLOPE_RST = 7'd2;
  localparam logic [15:0] COST_RST  = 16'd128;

  localparam logic OP_QUERY = 1'b0;
  localparam logic OP_REF   = 1'b1;

  // register index as seen on paddr[2]
  localparam logic REG_SLOPE = 1'b0;
  localparam logic REG_COST  = 1'b1;

  typedef struct packed {
    logic               opcode;
    logic signed [15:0] sample;
    logic [7:0]         class_label;
    logic               last;
  } in_t;

  typedef struct packed {
    logic [31:0] distance;
    logic [7:0]  best_class;
    logic [31:0] best_distance;
    logic        best_valid;
  } out_t;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_RUN    = 5'b00010,
    S_DRAIN  = 5'b00100,
    S_RES_RD = 5'b01000,
    S_RES    = 5'b10000
  } state_t;

  typedef struct packed {
    logic q_load;
    logic r_load;
    logic issue;
    logic col_end;
    logic res_rd;
    logic res_emit;
  } cmd_t;

  typedef struct packed {
    logic issue_done;
    logic pipe_empty;
    logic last_flag;
    logic out_free;
  } stat_t;

  function automatic logic [16:0] absdiff(input logic signed [15:0] a,
                                          input logic signed [15:0] b);
    logic signed [16:0] d;
    d = {a[15], a} - {b[15], b};
    absdiff = d[16] ? 17'(-d) : 17'(d);
  endfunction

  function automatic logic [17:0] split_merge(input logic signed [15:0] p,
                                              input logic signed [15:0] a,
                                              input logic signed [15:0] b,
                                              input logic [15:0]        c);
    logic [16:0] da;
    logic [16:0] db;
    logic [16:0] dm;
    da = absdiff(p, a);
    db = absdiff(p, b);
    dm = (da < db) ? da : db;
    if ((a <= p && p <= b) || (b <= p && p <= a)) begin
      split_merge = {2'b00, c};
    end else begin
      split_merge = {2'b00, c} + {1'b0, dm};
    end
  endfunction

  function automatic logic [31:0] sat_add(input logic [31:0] a,
                                          input logic [17:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {15'd0, b};
    if (a == COST_INF || s >= {1'b0, COST_INF}) begin
      sat_add = COST_INF;
    end else begin
      sat_add = s[31:0];
    end
  endfunction

endpackage

`default_nettype wire

// ----- design/msmnn_ctrl.sv -----
// ----------------------------------------------------------------------------
// msmnn_ctrl
// Sequencer: accepts words, walks one cost column per reference sample,
// drains the cell pipeline and emits results.
// ----------------------------------------------------------------------------
`default_nettype none

module msmnn_ctrl (
  input  wire              clk,
  input  wire              rst,
  input  wire              in_valid,
  input  wire              in_opcode,
  input  msmnn_pkg::stat_t stat,
  output msmnn_pkg::cmd_t  cmd,
  output logic             idle
);

  msmnn_pkg::state_t state;
  msmnn_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= msmnn_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    idle       = 1'b0;
    unique case (state)
      msmnn_pkg::S_IDLE: begin
        idle = 1'b1;
        if (in_valid) begin
          if (in_opcode == msmnn_pkg::OP_QUERY) begin
            cmd.q_load = 1'b1;
          end else begin
            cmd.r_load = 1'b1;
            state_next = msmnn_pkg::S_RUN;
          end
        end
      end
      msmnn_pkg::S_RUN: begin
        if (stat.issue_done) begin
          state_next = msmnn_pkg::S_DRAIN;
        end else begin
          cmd.issue = 1'b1;
        end
      end
      msmnn_pkg::S_DRAIN: begin
        if (stat.pipe_empty) begin
          cmd.col_end = 1'b1;
          state_next  = stat.last_flag ? msmnn_pkg::S_RES_RD : msmnn_pkg::S_IDLE;
        end
      end
      msmnn_pkg::S_RES_RD: begin
        cmd.res_rd = 1'b1;
        state_next = msmnn_pkg::S_RES;
      end
      msmnn_pkg::S_RES: begin
        cmd.res_rd = 1'b1;
        if (stat.out_free) begin
          cmd.res_emit = 1'b1;
          state_next   = msmnn_pkg::S_IDLE;
        end
      end
      default: state_next = msmnn_pkg::S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ----- design/msmnn_dp.sv -----
// ----------------------------------------------------------------------------
// msmnn_dp
// Datapath: query and cost memories, two-stage cell pipeline, best tracking
// and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module msmnn_dp #(
  parameter int MAX_LEN = msmnn_pkg::MAX_LEN_DEF
) (
  input  wire              clk,
  input  wire              rst,
  input  msmnn_pkg::in_t   in_data,
  input  msmnn_pkg::cmd_t  cmd,
  input  wire [6:0]        slope,
  input  wire [15:0]       sm_cost,
  input  wire              out_stall,
  output msmnn_pkg::stat_t stat,
  output logic             out_valid,
  output msmnn_pkg::out_t  out_data
);

  localparam int AW = $clog2(MAX_LEN);
  localparam int CW = $clog2(MAX_LEN + 1);
  localparam int PW = CW + 7;

  logic signed [15:0] q_mem [MAX_LEN];
  logic [31:0]        c_mem [MAX_LEN];

  logic [CW-1:0] qlen;
  logic          q_closed;
  logic [CW-1:0] ref_idx;
  logic [CW-1:0] issue_idx;
  logic signed [15:0] y_cur;
  logic signed [15:0] y_prev;
  logic [7:0]    label;
  logic          last_flag;
  logic [31:0]   best_cost;
  logic [7:0]    best_label;
  logic          best_found;

  logic signed [15:0] q_rd;
  logic [31:0]        c_rd;
  logic signed [15:0] x_prev;

  logic          s1_v;
  logic [AW-1:0] s1_idx;
  logic          s2_v;
  logic [AW-1:0] s2_idx;
  logic          s2_force_inf;
  logic          s2_init;
  logic [16:0]   s2_dd;
  logic [17:0]   s2_smu;
  logic [17:0]   s2_sml;
  logic [31:0]   s2_old;
  logic [31:0]   diag;
  logic [31:0]   up;

  logic          ref_active;
  logic [AW-1:0] qm1;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] q_wr_addr;
  logic          q_wr_en;

  assign ref_active = ref_idx < CW'(MAX_LEN);
  assign qm1        = AW'(qlen - CW'(1));
  assign rd_addr    = cmd.res_rd ? qm1 : issue_idx[AW-1:0];
  assign q_wr_addr  = q_closed ? '0 : qlen[AW-1:0];
  assign q_wr_en    = cmd.q_load && (q_closed || qlen < CW'(MAX_LEN));

  always_ff @(posedge clk) begin
    if (q_wr_en) begin
      q_mem[q_wr_addr] <= in_data.sample;
    end
    q_rd <= q_mem[rd_addr];
  end

  // stage 1: read data back, form the three step costs and the band test
  logic [PW-1:0] prod_i;
  logic [PW-1:0] prod_j;
  logic          out_band;
  logic          j_zero;
  logic          i_zero;

  assign prod_i   = PW'(slope) * PW'(s1_idx);
  assign prod_j   = PW'(slope) * PW'(ref_idx);
  assign out_band = (PW'(ref_idx) > prod_i) || (PW'(s1_idx) > prod_j);
  assign j_zero   = ref_idx == '0;
  assign i_zero   = s1_idx == '0;

  always_ff @(posedge clk) begin
    if (s1_v) begin
      x_prev       <= q_rd;
      s2_idx       <= s1_idx;
      s2_old       <= c_rd;
      s2_init      <= j_zero && i_zero;
      s2_force_inf <= j_zero ? !i_zero : (i_zero || out_band);
      s2_dd        <= msmnn_pkg::absdiff(q_rd, y_cur);
      s2_smu       <= msmnn_pkg::split_merge(q_rd, x_prev, y_cur, sm_cost);
      s2_sml       <= msmnn_pkg::split_merge(y_cur, q_rd, y_prev, sm_cost);
    end
  end

  // stage 2: saturating adds and the minimum, then write back
  logic [31:0] a_diag;
  logic [31:0] a_up;
  logic [31:0] a_left;
  logic [31:0] m_du;
  logic [31:0] nv;

  always_comb begin
    a_diag = msmnn_pkg::sat_add(diag, {1'b0, s2_dd});
    a_up   = msmnn_pkg::sat_add(up, s2_smu);
    a_left = msmnn_pkg::sat_add(s2_old, s2_sml);
    m_du   = (a_diag < a_up) ? a_diag : a_up;
    if (s2_force_inf) begin
      nv = msmnn_pkg::COST_INF;
    end else if (s2_init) begin
      nv = {15'd0, s2_dd};
    end else begin
      nv = (m_du < a_left) ? m_du : a_left;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_v) begin
      c_mem[s2_idx] <= nv;
      diag          <= s2_old;
      up            <= nv;
    end
    c_rd <= c_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
    end else begin
      s1_v <= cmd.issue;
      s2_v <= s1_v;
    end
    if (cmd.issue) begin
      s1_idx <= issue_idx[AW-1:0];
    end
  end

  // result path
  logic [31:0] col_dist;
  logic        better;

  assign col_dist = (qlen == '0) ? msmnn_pkg::COST_INF : c_rd;
  assign better   = col_dist < best_cost;

  always_ff @(posedge clk) begin
    if (rst) begin
      qlen       <= '0;
      q_closed   <= 1'b1;
      ref_idx    <= '0;
      issue_idx  <= '0;
      y_prev     <= '0;
      best_cost  <= msmnn_pkg::COST_INF;
      best_label <= '0;
      best_found <= 1'b0;
      last_flag  <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.q_load) begin
        ref_idx <= '0;
        if (q_closed) begin
          qlen       <= CW'(1);
          best_cost  <= msmnn_pkg::COST_INF;
          best_label <= '0;
          best_found <= 1'b0;
        end else if (qlen < CW'(MAX_LEN)) begin
          qlen <= qlen + CW'(1);
        end
        q_closed <= in_data.last;
      end
      if (cmd.r_load) begin
        y_cur     <= in_data.sample;
        label     <= in_data.class_label;
        last_flag <= in_data.last;
        issue_idx <= '0;
      end
      if (cmd.issue) begin
        issue_idx <= issue_idx + CW'(1);
      end
      if (cmd.col_end && ref_active) begin
        y_prev  <= y_cur;
        ref_idx <= ref_idx + CW'(1);
      end
      if (cmd.res_emit) begin
        ref_idx   <= '0;
        out_valid <= 1'b1;
        out_data.distance <= col_dist;
        if (better) begin
          best_cost  <= col_dist;
          best_label <= label;
          best_found <= 1'b1;
          out_data.best_class    <= label;
          out_data.best_distance <= col_dist;
          out_data.best_valid    <= 1'b1;
        end else begin
          out_data.best_class    <= best_label;
          out_data.best_distance <= best_cost;
          out_data.best_valid    <= best_found;
        end
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign stat.issue_done = (issue_idx == qlen) || !ref_active;
  assign stat.pipe_empty = !s1_v && !s2_v;
  assign stat.last_flag  = last_flag;
  assign stat.out_free   = !out_valid || !out_stall;

endmodule

`default_nettype wire

// ----- design/msm_distance_nearest_neighbour.sv -----
// ----------------------------------------------------------------------------
// msm_distance_nearest_neighbour
// MSM distance nearest neighbour classifier with an integer slope band.
// ----------------------------------------------------------------------------
//  channel  dir  handshake           word
//  in       in   in_valid/in_stall   msmnn_pkg::in_t
//  out      out  out_valid/out_stall msmnn_pkg::out_t
//  cfg      in   APB (psel/penable)  slope_limit @0x0, split_merge_cost @0x4
//
// A query word is stored while the block stays idle. A reference word issues
// one cost cell per cycle through a two-stage cell pipeline (none with an
// empty query or past MAX_LEN reference columns), then ends issue and drains.
// The last word of a reference then reads the result and waits for an earlier
// result still held under out_stall to leave before it emits its own.
// Synchronous reset; memories are not cleared. New words stall until idle.
// ----------------------------------------------------------------------------
`default_nettype none

module msm_distance_nearest_neighbour #(
  parameter int MAX_LEN = msmnn_pkg::MAX_LEN_DEF
) (
  input  wire             clk,
  input  wire             rst,
  input  wire             in_valid,
  output logic            in_stall,
  input  msmnn_pkg::in_t  in_data,
  output logic            out_valid,
  input  wire             out_stall,
  output msmnn_pkg::out_t out_data,
  input  wire             psel,
  input  wire             penable,
  input  wire             pwrite,
  input  wire [2:0]       paddr,
  input  wire [31:0]      pwdata,
  output logic [31:0]     prdata,
  output logic            pready
);

  logic [6:0]       slope;
  logic [15:0]      sm_cost;
  logic             idle;
  msmnn_pkg::cmd_t  cmd;
  msmnn_pkg::stat_t stat;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      slope   <= msmnn_pkg::SLOPE_RST;
      sm_cost <= msmnn_pkg::COST_RST;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == msmnn_pkg::REG_SLOPE) begin
        slope <= pwdata[6:0];
      end else begin
        sm_cost <= pwdata[15:0];
      end
    end
  end

  assign prdata = (paddr[2] == msmnn_pkg::REG_COST) ? {16'd0, sm_cost} : {25'd0, slope};

  assign in_stall = !idle;

  msmnn_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_opcode (in_data.opcode),
    .stat      (stat),
    .cmd       (cmd),
    .idle      (idle)
  );

  msmnn_dp #(.MAX_LEN(MAX_LEN)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .slope     (slope),
    .sm_cost   (sm_cost),
    .out_stall (out_stall),
    .stat      (stat),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.res_emit |-> (!out_valid || !out_stall))
    else $error("result loaded over a pending word");

  a_accept_empty: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |-> stat.pipe_empty)
    else $error("word accepted with cells in flight");

  a_best_finite: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!out_data.best_valid || out_data.best_distance != msmnn_pkg::COST_INF))
    else $error("best marked valid at infinity");

endmodule

`default_nettype wire
